[rtl/core/two_level_local_history_predictor_top_assert.svh]
// Assertion macros for the two-level local-history predictor.
// Used by the port checker; depends on clk and rst_n in the including scope.
`ifndef TWO_LEVEL_LOCAL_HISTORY_PREDICTOR_TOP_ASSERT_SVH
`define TWO_LEVEL_LOCAL_HISTORY_PREDICTOR_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent
`define TLHP_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent
`define TLHP_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/tlhp_pkg.sv]
// Shared types and constants of the two-level local-history predictor.
// No dependencies.
`timescale 1ns / 1ps

package tlhp_pkg;

    // Fixed field widths
    localparam int ID_W = 64;

    // Default geometry
    localparam int HISTORY_BITS_DEF  = 4;
    localparam int COUNTER_BITS_DEF  = 2;
    localparam int TABLE_ENTRIES_DEF = 1024;

    // Index reduction: id bits folded into the remainder per cycle
    localparam int REDUCE_BITS = 4;

    // Request mode codes
    localparam logic MODE_PREDICT = 1'b0;
    localparam logic MODE_OBSERVE = 1'b1;

    // Classified request word held in the queue
    typedef struct packed {
        logic            obs;
        logic [ID_W-1:0] planet_id;
        logic            hint;
        logic            outcome;
    } item_t;

endpackage

[rtl/core/tlhp_if.sv]
// Request and response channel interfaces of the predictor.
// Depends on tlhp_pkg.
`timescale 1ns / 1ps

interface tlhp_req_if;
    import tlhp_pkg::*;

    logic            valid;
    logic            ready;
    logic            mode;
    logic [ID_W-1:0] planet_id;
    logic            hint;
    logic            outcome;

    modport source (output valid, mode, planet_id, hint, outcome, input ready);
    modport sink   (input valid, mode, planet_id, hint, outcome, output ready);
endinterface

interface tlhp_rsp_if;
    logic valid;
    logic ready;
    logic prediction;

    modport source (output valid, prediction, input ready);
    modport sink   (input valid, prediction, output ready);
endinterface

[rtl/core/tlhp_front.sv]
// Front end: accepts request words, decodes the mode and queues them.
// Depends on tlhp_pkg and tlhp_if.
`timescale 1ns / 1ps

module tlhp_front (
    input  logic            clk,
    input  logic            rst_n,
    tlhp_req_if.sink        req,
    input  logic            clearing,
    output logic            q_valid,
    output tlhp_pkg::item_t q_item,
    input  logic            q_pop
);
    import tlhp_pkg::*;

    localparam int QDEPTH = 2;
    localparam int CNT_W  = $clog2(QDEPTH + 1);

    item_t            slot_reg [QDEPTH];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    item_t            in_item;
    logic             push;

    // Accept while there is room and the table is not being cleared
    assign req.ready = (cnt_reg != CNT_W'(QDEPTH)) && !clearing;
    assign push      = req.valid && req.ready;
    assign q_valid   = (cnt_reg != '0);
    assign q_item    = slot_reg[rd_ptr_reg];

    // Classify the incoming word
    always_comb
    begin
        in_item.planet_id = req.planet_id;
        in_item.hint      = req.hint;
        in_item.outcome   = req.outcome;
        case (req.mode)
            MODE_PREDICT: in_item.obs = 1'b0;
            MODE_OBSERVE: in_item.obs = 1'b1;
            default:      in_item.obs = 1'b0;
        endcase
    end

    // Queue pointers and fill count
    always_comb
    begin
        wr_ptr_next = push  ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        case ({push, q_pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

[rtl/core/tlhp_back.sv]
// Back end: index reduction, pattern table read-modify-write, result register.
// Depends on tlhp_pkg and tlhp_if.
`timescale 1ns / 1ps

module tlhp_back #(
    parameter int HISTORY_BITS  = tlhp_pkg::HISTORY_BITS_DEF,
    parameter int COUNTER_BITS  = tlhp_pkg::COUNTER_BITS_DEF,
    parameter int TABLE_ENTRIES = tlhp_pkg::TABLE_ENTRIES_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  tlhp_pkg::item_t q_item,
    output logic            q_pop,
    output logic            clearing,
    tlhp_rsp_if.source      rsp
);
    import tlhp_pkg::*;

    localparam int PATTERNS = 1 << HISTORY_BITS;
    localparam int ROW_W    = PATTERNS * COUNTER_BITS;
    localparam int IDX_W    = $clog2(TABLE_ENTRIES);
    localparam int REM_W    = IDX_W + 1;
    localparam bit IS_POW2  = (TABLE_ENTRIES == (1 << IDX_W));
    localparam int STEPS    = ID_W / REDUCE_BITS;
    localparam int STEP_W   = $clog2(STEPS);
    localparam logic [COUNTER_BITS-1:0] CTR_MAX = '1;

    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_REDUCE = 2'd2;
    localparam logic [1:0] ST_EXEC   = 2'd3;

    // Pattern table
    logic                    valid_mem [TABLE_ENTRIES];
    logic [ID_W-1:0]         tagp_mem  [TABLE_ENTRIES];
    logic [ID_W-1:0]         tagc_mem  [TABLE_ENTRIES];
    logic [HISTORY_BITS-1:0] hist_mem  [TABLE_ENTRIES];
    logic [ROW_W-1:0]        row_mem   [TABLE_ENTRIES];
    logic [PATTERNS-1:0]     pres_mem  [TABLE_ENTRIES];

    // Registered read data
    logic                    rd_valid_reg;
    logic [ID_W-1:0]         rd_tagp_reg;
    logic [ID_W-1:0]         rd_tagc_reg;
    logic [HISTORY_BITS-1:0] rd_hist_reg;
    logic [ROW_W-1:0]        rd_row_reg;
    logic [PATTERNS-1:0]     rd_pres_reg;

    // Control and item registers
    logic [1:0]        state_reg, state_next;
    logic [IDX_W-1:0]  clr_reg, clr_next;
    logic [ID_W-1:0]   prev_reg, prev_next;
    item_t             cur_reg, cur_next;
    logic [ID_W-1:0]   key_reg, key_next;
    logic [IDX_W-1:0]  rem_reg, rem_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [IDX_W-1:0]  addr_reg, addr_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_pred_reg, out_pred_next;

    // Datapath signals
    logic [ID_W-1:0]         new_key;
    logic [REM_W-1:0]        rem_work;
    logic [ID_W-1:0]         key_work;
    logic [IDX_W-1:0]        rem_step;
    logic [ID_W-1:0]         key_step;
    logic                    rd_en;
    logic [IDX_W-1:0]        rd_addr;
    logic                    wr_en;
    logic                    vwr_en;
    logic [IDX_W-1:0]        vwr_addr;
    logic                    vwr_data;
    logic                    hit;
    logic [COUNTER_BITS-1:0] sel_ctr;
    logic                    sel_pres;
    logic                    pred;
    logic [COUNTER_BITS-1:0] base_ctr;
    logic [COUNTER_BITS-1:0] trained;
    logic [ROW_W-1:0]        row_new;
    logic [PATTERNS-1:0]     pres_new;
    logic [HISTORY_BITS-1:0] hist_new;

    assign clearing  = (state_reg == ST_CLEAR);
    assign rsp.valid = out_valid_reg;
    assign rsp.prediction = out_pred_reg;
    assign new_key   = prev_reg ^ q_item.planet_id;

    // Index reduction: REDUCE_BITS remainder steps per cycle, MSB first
    always_comb
    begin
        rem_work = {1'b0, rem_reg};
        key_work = key_reg;
        for (int k = 0; k < REDUCE_BITS; k++)
        begin
            rem_work = {rem_work[IDX_W-1:0], key_work[ID_W-1]};
            key_work = key_work << 1;
            if (rem_work >= REM_W'(TABLE_ENTRIES))
            begin
                rem_work = rem_work - REM_W'(TABLE_ENTRIES);
            end
        end
        rem_step = rem_work[IDX_W-1:0];
        key_step = key_work;
    end

    // Lookup: tag match and counter select for the current history
    always_comb
    begin
        hit = rd_valid_reg && (rd_tagp_reg == prev_reg) &&
              (rd_tagc_reg == cur_reg.planet_id);
        sel_ctr  = '0;
        sel_pres = 1'b0;
        for (int p = 0; p < PATTERNS; p++)
        begin
            if (HISTORY_BITS'(p) == rd_hist_reg)
            begin
                sel_ctr  = rd_row_reg[p*COUNTER_BITS +: COUNTER_BITS];
                sel_pres = rd_pres_reg[p];
            end
        end
        pred = (hit && sel_pres) ? sel_ctr[COUNTER_BITS-1] : cur_reg.hint;
    end

    // Training and history update for observe words
    always_comb
    begin
        base_ctr = sel_pres ? sel_ctr : '0;
        if (cur_reg.outcome)
        begin
            trained = (base_ctr == CTR_MAX) ? base_ctr : base_ctr + 1'b1;
        end
        else
        begin
            trained = (base_ctr == '0) ? base_ctr : base_ctr - 1'b1;
        end

        if (hit)
        begin
            row_new  = rd_row_reg;
            pres_new = rd_pres_reg;
            for (int p = 0; p < PATTERNS; p++)
            begin
                if (HISTORY_BITS'(p) == rd_hist_reg)
                begin
                    row_new[p*COUNTER_BITS +: COUNTER_BITS] = trained;
                    pres_new[p] = 1'b1;
                end
            end
            hist_new = HISTORY_BITS'({rd_hist_reg, cur_reg.outcome});
        end
        else
        begin
            // Allocate: pattern zero present at zero, history takes the outcome
            row_new  = '0;
            pres_new = PATTERNS'(1);
            hist_new = HISTORY_BITS'(cur_reg.outcome);
        end
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        prev_next      = prev_reg;
        cur_next       = cur_reg;
        key_next       = key_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        addr_next      = addr_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_pred_next  = out_pred_reg;
        q_pop          = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = addr_reg;
        wr_en          = 1'b0;
        vwr_en         = 1'b0;
        vwr_addr       = addr_reg;
        vwr_data       = 1'b1;

        case (state_reg)
            ST_CLEAR:
            begin
                vwr_en   = 1'b1;
                vwr_addr = clr_reg;
                vwr_data = 1'b0;
                if (clr_reg == IDX_W'(TABLE_ENTRIES - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    cur_next = q_item;
                    if (IS_POW2)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = new_key[IDX_W-1:0];
                        addr_next  = new_key[IDX_W-1:0];
                        state_next = ST_EXEC;
                    end
                    else
                    begin
                        key_next   = new_key;
                        rem_next   = '0;
                        step_next  = '0;
                        state_next = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE:
            begin
                key_next  = key_step;
                rem_next  = rem_step;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(STEPS - 1))
                begin
                    rd_en      = 1'b1;
                    rd_addr    = rem_step;
                    addr_next  = rem_step;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (cur_reg.obs)
                begin
                    wr_en      = 1'b1;
                    vwr_en     = 1'b1;
                    prev_next  = cur_reg.planet_id;
                    state_next = ST_IDLE;
                end
                else if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_pred_next  = pred;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            prev_reg      <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            prev_reg      <= prev_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        key_reg      <= key_next;
        rem_reg      <= rem_next;
        addr_reg     <= addr_next;
        out_pred_reg <= out_pred_next;
    end

    // Table read port (registered) and write port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_valid_reg <= valid_mem[rd_addr];
            rd_tagp_reg  <= tagp_mem[rd_addr];
            rd_tagc_reg  <= tagc_mem[rd_addr];
            rd_hist_reg  <= hist_mem[rd_addr];
            rd_row_reg   <= row_mem[rd_addr];
            rd_pres_reg  <= pres_mem[rd_addr];
        end
        if (vwr_en)
        begin
            valid_mem[vwr_addr] <= vwr_data;
        end
        if (wr_en)
        begin
            tagp_mem[addr_reg] <= prev_reg;
            tagc_mem[addr_reg] <= cur_reg.planet_id;
            hist_mem[addr_reg] <= hist_new;
            row_mem[addr_reg]  <= row_new;
            pres_mem[addr_reg] <= pres_new;
        end
    end

endmodule

[rtl/core/two_level_local_history_predictor_top.sv]
// Two-level local-history predictor. Each request word is keyed by the pair
// (previous observed id, planet_id) and selects one line of a direct-mapped
// tagged table indexed by (previous id xor planet_id) mod TABLE_ENTRIES. A line
// keeps an outcome history and a private row of saturating counters, one per
// history pattern. Predict words (mode 0) return one response word; observe
// words (mode 1) train the table and return nothing. After reset the table's
// valid bits are swept, one line per cycle, while req.ready stays low. Words
// are then handled one at a time: a table read, then a read-modify-write,
// when TABLE_ENTRIES is a power of two, and otherwise an index remainder
// computation, four id bits per cycle, in front of the table read. A two-word
// queue in front and a response register at the output let the request side
// keep filling while a response waits.
// Depends on tlhp_pkg, tlhp_if, tlhp_front and tlhp_back.
`timescale 1ns / 1ps

module two_level_local_history_predictor_top #(
    parameter int HISTORY_BITS  = tlhp_pkg::HISTORY_BITS_DEF,
    parameter int COUNTER_BITS  = tlhp_pkg::COUNTER_BITS_DEF,
    parameter int TABLE_ENTRIES = tlhp_pkg::TABLE_ENTRIES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    tlhp_req_if.sink   req,
    tlhp_rsp_if.source rsp
);
    import tlhp_pkg::*;

    logic  q_valid;
    item_t q_item;
    logic  q_pop;
    logic  clearing;

    // Request queue and mode decode
    tlhp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .clearing (clearing),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    // Table access and response
    tlhp_back #(
        .HISTORY_BITS  (HISTORY_BITS),
        .COUNTER_BITS  (COUNTER_BITS),
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .clearing (clearing),
        .rsp      (rsp)
    );

endmodule

[rtl/core/tlhp_port_checker.sv]
// Port-level checks of the predictor, bound to the top level.
// Depends on two_level_local_history_predictor_top_assert.svh.
`timescale 1ns / 1ps
`include "two_level_local_history_predictor_top_assert.svh"

module tlhp_port_checker (
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input logic prediction
);

    // A stalled response word keeps its value
    `TLHP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(prediction), "response changed while stalled")

    // Nothing moves in the first cycle out of reset
    `TLHP_ASSERT_NOW(a_quiet_after_reset, !$past(rst_n), !req_ready && !rsp_valid, "activity right after reset")

    // The table sweep after reset keeps requests out
    `TLHP_ASSERT_NOW(a_sweep_blocks, !$past(rst_n), ##15 !req_ready, "requests taken during table sweep")

endmodule

bind two_level_local_history_predictor_top tlhp_port_checker u_port_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .prediction (rsp.prediction)
);
